FILE: hdl/mfb_pkg.sv
// Shared constants and types for the max-flow engine.
package mfb_pkg;

    localparam int NODE_COUNT_DEF = 128;
    localparam int CAP_WIDTH_DEF  = 16;
    localparam int TOTAL_W        = 23;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 23'd8388607;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_RUN    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ADDR_SOURCE = 3'd0;
    localparam logic [2:0] ADDR_SINK   = 3'd4;

    typedef enum logic [3:0] {
        ST_CLR_CAP,
        ST_IDLE,
        ST_CLR_FLOW,
        ST_SRCH_CLR,
        ST_SEED,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_BN_PAR_RD,
        ST_BN_PAR_WAIT,
        ST_BN_EDGE_EV,
        ST_AUG_PAR_RD,
        ST_AUG_PAR_WAIT,
        ST_AUG_FWD,
        ST_AUG_REV
    } state_t;

endpackage

FILE: hdl/max_flow_bfs_augment_core.sv
// Edmonds-Karp max-flow engine: capacity/flow matrices, BFS, augmentation.
// A capacity write goes straight into the matrix; a clear zeroes all 2**(2*ceil(log2 N)) matrix entries.
// A run clears the flow matrix, then each search clears the parent table, scans the
// neighbours of each popped node and makes one-port walks of the path.
// Reset starts a capacity clearing pass over every matrix entry with busy high.
// The single total_flow word is strobed by done for one cycle; the receiver cannot stall.
module max_flow_bfs_augment_core #(
    parameter int NODE_COUNT = mfb_pkg::NODE_COUNT_DEF,
    parameter int CAP_WIDTH  = mfb_pkg::CAP_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [6:0]  from_node,
    input  logic [6:0]  to_node,
    input  logic [15:0] capacity,
    output logic        done,
    output logic [22:0] total_flow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NW  = $clog2(NODE_COUNT);
    localparam int AW  = 2 * NW;
    localparam int MD  = 1 << AW;
    localparam int FW  = CAP_WIDTH + 1;
    localparam int RW  = CAP_WIDTH + 2;
    localparam int SW  = (RW > 24) ? RW : 24;
    localparam logic [RW-1:0] RES_MAX = {1'b0, {(RW-1){1'b1}}};

    mfb_pkg::state_t state_reg, state_next;

    logic [6:0]            source_reg, source_next;
    logic [6:0]            sink_reg, sink_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic [NW-1:0]         x_reg, x_next;
    logic [NW-1:0]         y_reg, y_next;
    logic [NW-1:0]         i_reg, i_next;
    logic [NW-1:0]         p_reg, p_next;
    logic [NW:0]           head_reg, head_next;
    logic [NW:0]           tail_reg, tail_next;
    logic signed [RW-1:0]  bn_reg, bn_next;
    logic [22:0]           acc_reg, acc_next;
    logic                  done_reg, done_next;
    logic [22:0]           total_reg, total_next;

    logic                  cap_we;
    logic [AW-1:0]         cap_waddr;
    logic [CAP_WIDTH-1:0]  cap_wdata;
    logic [CAP_WIDTH-1:0]  cap_rdata;
    logic                  flow_we;
    logic [AW-1:0]         flow_waddr;
    logic [FW-1:0]         flow_wdata;
    logic [FW-1:0]         flow_rdata;
    logic [AW-1:0]         mat_raddr;
    logic                  par_we;
    logic [NW-1:0]         par_waddr;
    logic [NW:0]           par_wdata;
    logic [NW-1:0]         par_raddr;
    logic [NW:0]           par_rdata;
    logic                  q_we;
    logic [NW-1:0]         q_waddr;
    logic [NW-1:0]         q_wdata;
    logic [NW-1:0]         q_rdata;
    logic [NW-1:0]         q_raddr_w;

    logic [NW-1:0]         src_n;
    logic [NW-1:0]         dst_n;
    logic                  run_ok;
    logic signed [RW-1:0]  res;
    logic [SW-1:0]         acc_sum;
    logic [22:0]           acc_sat;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign busy   = (state_reg != mfb_pkg::ST_IDLE);
    assign done   = done_reg;
    assign total_flow = total_reg;
    assign prdata = paddr[2] ? {25'd0, sink_reg} : {25'd0, source_reg};
    assign cfg_wr = psel & penable & pwrite;

    assign src_n  = NW'(source_reg);
    assign dst_n  = NW'(sink_reg);
    assign run_ok = (32'(source_reg) < NODE_COUNT) && (32'(sink_reg) < NODE_COUNT)
                    && (source_reg != sink_reg);
    assign res    = RW'($signed({1'b0, cap_rdata})) - RW'($signed(flow_rdata));
    assign acc_sum = SW'(acc_reg) + SW'(bn_reg[RW-2:0]);
    assign acc_sat = (acc_sum > SW'(mfb_pkg::TOTAL_MAX)) ? mfb_pkg::TOTAL_MAX
                                                          : acc_sum[22:0];
    assign q_raddr_w = head_reg[NW-1:0];

    mfb_ram #(.WIDTH(CAP_WIDTH), .DEPTH(MD)) u_cap_ram (
        .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
        .raddr(mat_raddr), .rdata(cap_rdata)
    );

    mfb_ram #(.WIDTH(FW), .DEPTH(MD)) u_flow_ram (
        .clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
        .raddr(mat_raddr), .rdata(flow_rdata)
    );

    // Each parent entry holds a visited flag above the parent index.
    mfb_ram #(.WIDTH(NW + 1), .DEPTH(NODE_COUNT)) u_par_ram (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    mfb_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_queue_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr_w), .rdata(q_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mfb_pkg::ST_CLR_CAP;
            source_reg <= 7'd0;
            sink_reg   <= 7'd1;
            cnt_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            i_reg      <= '0;
            p_reg      <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            bn_reg     <= '0;
            acc_reg    <= '0;
            done_reg   <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            source_reg <= source_next;
            sink_reg   <= sink_next;
            cnt_reg    <= cnt_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            i_reg      <= i_next;
            p_reg      <= p_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            bn_reg     <= bn_next;
            acc_reg    <= acc_next;
            done_reg   <= done_next;
            total_reg  <= total_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        source_next = source_reg;
        sink_next   = sink_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        i_next      = i_reg;
        p_next      = p_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        bn_next     = bn_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        total_next  = total_reg;

        cap_we     = 1'b0;
        cap_waddr  = cnt_reg;
        cap_wdata  = '0;
        flow_we    = 1'b0;
        flow_waddr = cnt_reg;
        flow_wdata = '0;
        mat_raddr  = {x_reg, y_reg};
        par_we     = 1'b0;
        par_waddr  = y_reg;
        par_wdata  = '0;
        par_raddr  = i_reg;
        q_we       = 1'b0;
        q_waddr    = tail_reg[NW-1:0];
        q_wdata    = y_reg;

        if (cfg_wr)
        begin
            if (paddr[2])
            begin
                sink_next = pwdata[6:0];
            end
            else
            begin
                source_next = pwdata[6:0];
            end
        end

        unique case (state_reg)
            mfb_pkg::ST_CLR_CAP:
            begin
                cap_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = mfb_pkg::ST_IDLE;
                end
            end
            mfb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    priority case (kind)
                        mfb_pkg::KIND_WRITE:
                        begin
                            if ((32'(from_node) < NODE_COUNT) && (32'(to_node) < NODE_COUNT))
                            begin
                                cap_we    = 1'b1;
                                cap_waddr = {NW'(from_node), NW'(to_node)};
                                cap_wdata = CAP_WIDTH'(capacity);
                            end
                        end
                        mfb_pkg::KIND_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = mfb_pkg::ST_CLR_CAP;
                        end
                        mfb_pkg::KIND_RUN:
                        begin
                            acc_next = '0;
                            if (run_ok)
                            begin
                                cnt_next   = '0;
                                state_next = mfb_pkg::ST_CLR_FLOW;
                            end
                            else
                            begin
                                done_next  = 1'b1;
                                total_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mfb_pkg::ST_CLR_FLOW:
            begin
                flow_we  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    y_next     = '0;
                    state_next = mfb_pkg::ST_SRCH_CLR;
                end
            end
            mfb_pkg::ST_SRCH_CLR:
            begin
                par_we = 1'b1;
                y_next = y_reg + 1'b1;
                if (32'(y_reg) == NODE_COUNT - 1)
                begin
                    state_next = mfb_pkg::ST_SEED;
                end
            end
            mfb_pkg::ST_SEED:
            begin
                par_we     = 1'b1;
                par_waddr  = src_n;
                par_wdata  = {1'b1, {NW{1'b0}}};
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = src_n;
                head_next  = '0;
                tail_next  = (NW + 1)'(1);
                state_next = mfb_pkg::ST_POP_RD;
            end
            mfb_pkg::ST_POP_RD:
            begin
                if (head_reg == tail_reg)
                begin
                    // The sink is unreachable: the run is over.
                    done_next  = 1'b1;
                    total_next = acc_reg;
                    state_next = mfb_pkg::ST_IDLE;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = mfb_pkg::ST_POP_WAIT;
                end
            end
            mfb_pkg::ST_POP_WAIT:
            begin
                x_next     = q_rdata;
                y_next     = '0;
                state_next = mfb_pkg::ST_SCAN_RD;
            end
            mfb_pkg::ST_SCAN_RD:
            begin
                par_raddr  = y_reg;
                state_next = mfb_pkg::ST_SCAN_EV;
            end
            mfb_pkg::ST_SCAN_EV:
            begin
                if (!par_rdata[NW] && (res > 0))
                begin
                    par_we    = 1'b1;
                    par_waddr = y_reg;
                    par_wdata = {1'b1, x_reg};
                    if (32'(tail_reg) < NODE_COUNT)
                    begin
                        q_we      = 1'b1;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                if (!par_rdata[NW] && (res > 0) && (y_reg == dst_n))
                begin
                    i_next     = dst_n;
                    bn_next    = RES_MAX;
                    state_next = mfb_pkg::ST_BN_PAR_RD;
                end
                else if (32'(y_reg) == NODE_COUNT - 1)
                begin
                    state_next = mfb_pkg::ST_POP_RD;
                end
                else
                begin
                    y_next     = y_reg + 1'b1;
                    state_next = mfb_pkg::ST_SCAN_RD;
                end
            end
            mfb_pkg::ST_BN_PAR_RD:
            begin
                if (i_reg == src_n)
                begin
                    i_next     = dst_n;
                    state_next = mfb_pkg::ST_AUG_PAR_RD;
                end
                else
                begin
                    state_next = mfb_pkg::ST_BN_PAR_WAIT;
                end
            end
            mfb_pkg::ST_BN_PAR_WAIT:
            begin
                mat_raddr  = {par_rdata[NW-1:0], i_reg};
                p_next     = par_rdata[NW-1:0];
                state_next = mfb_pkg::ST_BN_EDGE_EV;
            end
            mfb_pkg::ST_BN_EDGE_EV:
            begin
                if (res < bn_reg)
                begin
                    bn_next = res;
                end
                i_next     = p_reg;
                state_next = mfb_pkg::ST_BN_PAR_RD;
            end
            mfb_pkg::ST_AUG_PAR_RD:
            begin
                if (i_reg == src_n)
                begin
                    acc_next   = acc_sat;
                    y_next     = '0;
                    state_next = mfb_pkg::ST_SRCH_CLR;
                end
                else
                begin
                    state_next = mfb_pkg::ST_AUG_PAR_WAIT;
                end
            end
            mfb_pkg::ST_AUG_PAR_WAIT:
            begin
                mat_raddr  = {par_rdata[NW-1:0], i_reg};
                p_next     = par_rdata[NW-1:0];
                state_next = mfb_pkg::ST_AUG_FWD;
            end
            mfb_pkg::ST_AUG_FWD:
            begin
                // Forward edge gains the bottleneck; the reverse edge is read meanwhile.
                flow_we    = 1'b1;
                flow_waddr = {p_reg, i_reg};
                flow_wdata = FW'(RW'($signed(flow_rdata)) + bn_reg);
                mat_raddr  = {i_reg, p_reg};
                state_next = mfb_pkg::ST_AUG_REV;
            end
            mfb_pkg::ST_AUG_REV:
            begin
                flow_we    = 1'b1;
                flow_waddr = {i_reg, p_reg};
                flow_wdata = FW'(RW'($signed(flow_rdata)) - bn_reg);
                i_next     = p_reg;
                state_next = mfb_pkg::ST_AUG_PAR_RD;
            end
            default:
            begin
                state_next = mfb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/mfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sim/tb_top.sv
// Testbench for the max-flow engine: directed cases, then random graph phases.
`timescale 1ns / 1ps

module tb_top;

    localparam int NODES = 128;

    // Predicts the total flow of each run word from its own copy of the capacities.
    class flow_board;
        bit [15:0]   cap_mem [NODES*NODES];
        longint      flow_mem [NODES*NODES];
        bit [6:0]    src_reg;
        bit [6:0]    snk_reg;
        bit [22:0]   pending_totals [$];
        int          errors;

        function new();
            foreach (cap_mem[i]) cap_mem[i] = '0;
            src_reg = 7'd0;
            snk_reg = 7'd1;
            errors = 0;
        endfunction

        function longint resid(int x, int y);
            return longint'(cap_mem[x*NODES+y]) - flow_mem[x*NODES+y];
        endfunction

        function bit find_path(int s, int d, ref int par[NODES]);
            bit seen [NODES];
            int q [NODES];
            int head;
            int tail;
            int x;
            head = 0;
            tail = 0;
            foreach (seen[i]) seen[i] = 0;
            seen[s] = 1;
            q[tail++] = s;
            while (head < tail) begin
                x = q[head++];
                for (int y = 0; y < NODES; y++) begin
                    if (!seen[y] && resid(x, y) > 0) begin
                        seen[y] = 1;
                        par[y] = x;
                        if (tail < NODES) q[tail++] = y;
                        if (y == d) return 1;
                    end
                end
            end
            return 0;
        endfunction

        function bit [22:0] max_flow();
            int par [NODES];
            longint bn;
            longint r;
            longint acc;
            int s;
            int d;
            s = int'(src_reg);
            d = int'(snk_reg);
            acc = 0;
            foreach (flow_mem[i]) flow_mem[i] = 0;
            if (s == d) return '0;
            while (find_path(s, d, par)) begin
                bn = -1;
                for (int i = d; i != s; i = par[i]) begin
                    r = resid(par[i], i);
                    if (bn < 0 || r < bn) bn = r;
                end
                for (int i = d; i != s; i = par[i]) begin
                    flow_mem[par[i]*NODES+i] += bn;
                    flow_mem[i*NODES+par[i]] -= bn;
                end
                acc += bn;
            end
            return (acc > longint'(mfb_pkg::TOTAL_MAX)) ? mfb_pkg::TOTAL_MAX : acc[22:0];
        endfunction

        function void note_item(bit [1:0] k, bit [6:0] f, bit [6:0] t, bit [15:0] c);
            bit [22:0] want;
            if (k == mfb_pkg::KIND_WRITE)
                cap_mem[int'(f)*NODES+int'(t)] = c;
            else if (k == mfb_pkg::KIND_CLEAR)
                foreach (cap_mem[i]) cap_mem[i] = '0;
            else if (k == mfb_pkg::KIND_RUN) begin
                want = max_flow();
                pending_totals = {pending_totals, want};
            end
        endfunction

        function void check_total(bit [22:0] got);
            bit [22:0] want;
            if (pending_totals.size() == 0) begin
                $error("total_flow: unexpected word, actual %0d", got);
                errors++;
                return;
            end
            want = pending_totals.pop_front();
            if (want !== got) begin
                $error("total_flow: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [6:0]  from_node;
    logic [6:0]  to_node;
    logic [15:0] capacity;
    logic        done;
    logic [22:0] total_flow;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    flow_board board;
    int        items_sent;

    max_flow_bfs_augment_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .from_node  (from_node),
        .to_node    (to_node),
        .capacity   (capacity),
        .done       (done),
        .total_flow (total_flow),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) board.check_total(total_flow);
    end

    task automatic send_word(bit [1:0] k, bit [6:0] f, bit [6:0] t, bit [15:0] c);
        int gap;
        gap = $urandom_range(0, 6);
        start     <= 1'b1;
        kind      <= k;
        from_node <= f;
        to_node   <= t;
        capacity  <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        board.note_item(k, f, t, c);
        items_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lets all outstanding work finish so the registers may be changed.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_totals.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(bit [2:0] addr, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == mfb_pkg::ADDR_SOURCE) board.src_reg = value[6:0];
        else board.snk_reg = value[6:0];
        @(posedge clk);
    endtask

    task automatic set_ends(bit [6:0] s, bit [6:0] d);
        drain();
        write_reg(mfb_pkg::ADDR_SOURCE, {25'd0, s});
        write_reg(mfb_pkg::ADDR_SINK, {25'd0, d});
    endtask

    initial
    begin
        #400_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        bit [6:0]  pool [10];
        int        pool_n;
        int        edges;
        bit [15:0] c;
        board = new();
        items_sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = mfb_pkg::KIND_WRITE;
        from_node = '0;
        to_node = '0;
        capacity = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extremes, every kind, the special cases.
        set_ends(7'd0, 7'd1);
        send_word(mfb_pkg::KIND_WRITE, 7'd0, 7'd1, 16'hFFFF);
        send_word(mfb_pkg::KIND_WRITE, 7'd0, 7'd2, 16'd5);
        send_word(mfb_pkg::KIND_WRITE, 7'd2, 7'd1, 16'd7);
        send_word(mfb_pkg::KIND_RUN, 7'd0, 7'd0, 16'd0);
        send_word(mfb_pkg::KIND_UNUSED, 7'd127, 7'd127, 16'hFFFF);
        // The source sits at the end of an edge back into it, so it must never get a parent.
        send_word(mfb_pkg::KIND_WRITE, 7'd2, 7'd0, 16'd9);
        send_word(mfb_pkg::KIND_RUN, 7'd0, 7'd0, 16'd0);
        set_ends(7'd127, 7'd0);
        send_word(mfb_pkg::KIND_WRITE, 7'd127, 7'd0, 16'd0);
        send_word(mfb_pkg::KIND_RUN, 7'd0, 7'd0, 16'd0);
        send_word(mfb_pkg::KIND_WRITE, 7'd127, 7'd64, 16'd3);
        send_word(mfb_pkg::KIND_WRITE, 7'd64, 7'd0, 16'd2);
        send_word(mfb_pkg::KIND_RUN, 7'd0, 7'd0, 16'd0);
        set_ends(7'd127, 7'd127);
        send_word(mfb_pkg::KIND_RUN, 7'd0, 7'd0, 16'd0);
        set_ends(7'd0, 7'd1);
        for (int i = 2; i < 8; i++)
        begin
            send_word(mfb_pkg::KIND_WRITE, 7'd0, i[6:0], 16'hFFFF);
            send_word(mfb_pkg::KIND_WRITE, i[6:0], 7'd1, 16'hFFFF);
        end
        send_word(mfb_pkg::KIND_RUN, 7'd0, 7'd0, 16'd0);
        send_word(mfb_pkg::KIND_CLEAR, 7'd0, 7'd0, 16'd0);
        send_word(mfb_pkg::KIND_RUN, 7'd0, 7'd0, 16'd0);

        // Random phases: a small node pool, an optional clear, a burst of edge writes, then one or two runs.
        while (items_sent < 500)
        begin
            pool_n = $urandom_range(3, 10);
            for (int i = 0; i < pool_n; i++) pool[i] = 7'($urandom_range(0, 127));
            set_ends(pool[0], pool[$urandom_range(1, pool_n - 1)]);
            if ($urandom_range(0, 1))
                send_word(mfb_pkg::KIND_CLEAR, 7'($urandom), 7'($urandom), 16'($urandom));
            edges = $urandom_range(6, 16);
            for (int e = 0; e < edges; e++)
            begin
                case ($urandom_range(0, 7))
                    0: c = 16'd0;
                    1: c = 16'hFFFF;
                    default: c = 16'($urandom_range(1, 65535));
                endcase
                if ($urandom_range(0, 9) == 0)
                    send_word(mfb_pkg::KIND_UNUSED, 7'($urandom), 7'($urandom),
                              16'($urandom));
                else if ($urandom_range(0, 9) == 0)
                    send_word(mfb_pkg::KIND_WRITE, 7'($urandom), 7'($urandom),
                              16'($urandom));
                else
                    send_word(mfb_pkg::KIND_WRITE, pool[$urandom_range(0, pool_n - 1)],
                              pool[$urandom_range(0, pool_n - 1)], c);
            end
            send_word(mfb_pkg::KIND_RUN, 7'($urandom), 7'($urandom), 16'($urandom));
            if ($urandom_range(0, 3) == 0)
                send_word(mfb_pkg::KIND_RUN, 7'($urandom), 7'($urandom), 16'($urandom));
        end

        drain();
        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.pending_totals.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
